// ===== src/frnn_pkg.sv =====
// ----------------------------------------------------------------------------
// frnn_pkg
// Shared types and constants for the fixed-radius neighbor search block.
// ----------------------------------------------------------------------------
package frnn_pkg;

	localparam int COORD_BITS     = 16;
	localparam int IDX_BITS       = 6;
	localparam int CNT_BITS       = 7;
	localparam int RADIUS_BITS    = 16;
	localparam int DIST_BITS      = 17;
	localparam int MAX_POINTS_DEF = 64;

	// squared distance: two squares of a COORD_BITS magnitude, plus a carry
	localparam int SQ_BITS   = 2 * COORD_BITS;
	localparam int D2_BITS   = SQ_BITS + 1;
	// root datapath width, rounded up to an even number of bits
	localparam int ROOT_BITS = D2_BITS + (D2_BITS % 2);

	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = RADIUS_BITS'(200);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic                          op;
		logic [IDX_BITS-1:0]           point_index;
		logic signed [COORD_BITS-1:0]  coord_x;
		logic signed [COORD_BITS-1:0]  coord_y;
		logic [CNT_BITS-1:0]           point_count;
	} item_t;

	typedef struct packed {
		logic                  valid_res;
		logic [IDX_BITS-1:0]   neighbor_count;
		logic [DIST_BITS-1:0]  nearest_distance;
		logic [IDX_BITS-1:0]   closest_index;
	} result_t;

	typedef struct packed {
		logic wr;          // point write transaction taken
		logic start;       // query transaction taken
		logic cap_q;       // capture query point from table read
		logic issue;       // issue one scan read
		logic root_start;  // launch square root of best distance
		logic res_load;    // move result into output register
	} frnn_cmd_t;

	typedef struct packed {
		logic q_ok;        // query index and count are usable
		logic scan_last;   // current scan read is the final one
		logic pipe_busy;   // distance pipeline still holds items
		logic root_done;   // square root finished
	} frnn_stat_t;

endpackage

// ===== src/frnn_ram.sv =====
// ----------------------------------------------------------------------------
// frnn_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module frnn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/frnn_sqrt.sv =====
// ----------------------------------------------------------------------------
// frnn_sqrt
// Iterative floor integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module frnn_sqrt
	import frnn_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [D2_BITS-1:0]   operand,
	output logic                 done,
	output logic [DIST_BITS-1:0] root
);

	logic                 busy_q;
	logic                 done_q;
	logic [ROOT_BITS-1:0] rem_q;
	logic [ROOT_BITS-1:0] res_q;
	logic [ROOT_BITS-1:0] bit_q;
	logic [ROOT_BITS-1:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= ROOT_BITS'(operand);
			res_q <= '0;
			bit_q <= ROOT_BITS'(1) << (ROOT_BITS - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[DIST_BITS-1:0];

endmodule

// ===== src/frnn_dp.sv =====
// ----------------------------------------------------------------------------
// frnn_dp
// Datapath: point table, scan address counter, distance pipeline,
// nearest tracking and square root.
// ----------------------------------------------------------------------------
module frnn_dp
	import frnn_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [RADIUS_BITS-1:0] cfg_wdata,
	input  item_t                  item,
	input  frnn_cmd_t              cmd,
	output frnn_stat_t             stat,
	output result_t                result
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic [RADIUS_BITS-1:0] radius_q;
	logic [SQ_BITS-1:0]     r2_q;

	logic [CW-1:0]          cnt_sat;
	logic                   q_ok;
	logic                   wr_ok;

	logic [AW-1:0]          qidx_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          scan_q;
	logic                   qok_q;
	logic signed [COORD_BITS-1:0] qx_q;
	logic signed [COORD_BITS-1:0] qy_q;

	logic [AW-1:0]           raddr;
	logic [2*COORD_BITS-1:0] rdata;
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;
	logic signed [COORD_BITS:0]   diff_x;
	logic signed [COORD_BITS:0]   diff_y;
	logic [COORD_BITS:0]          abs_x;
	logic [COORD_BITS:0]          abs_y;

	logic                  v_s0, v_s1, v_s2, v_s3;
	logic [AW-1:0]         i_s0, i_s1, i_s2, i_s3;
	logic                  self_s1, self_s2;
	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	logic [SQ_BITS-1:0]    sqx_s2, sqy_s2;
	logic [D2_BITS-1:0]    d2_s3;

	logic                  hit;
	logic [IDX_BITS-1:0]   found_q;
	logic                  have_q;
	logic [D2_BITS-1:0]    best_d2_q;
	logic [AW-1:0]         best_i_q;

	logic                  root_done;
	logic [DIST_BITS-1:0]  root;

	// radius register and its square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_wen) begin
			radius_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		r2_q <= SQ_BITS'(radius_q * radius_q);
	end

	// query and write index checks on the incoming item
	always_comb begin
		if (int'(item.point_count) > MAX_POINTS) begin
			cnt_sat = CW'(MAX_POINTS);
		end else begin
			cnt_sat = CW'(item.point_count);
		end
		q_ok  = (cnt_sat != '0) && (int'(item.point_index) < int'(cnt_sat));
		wr_ok = int'(item.point_index) < MAX_POINTS;
	end

	assign raddr = cmd.issue ? scan_q[AW-1:0] : AW'(item.point_index);

	frnn_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (cmd.wr && wr_ok),
		.waddr (AW'(item.point_index)),
		.wdata ({item.coord_y, item.coord_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign px = rdata[COORD_BITS-1:0];
	assign py = rdata[2*COORD_BITS-1:COORD_BITS];

	// query setup and scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			qok_q  <= 1'b0;
		end else if (cmd.start) begin
			scan_q <= '0;
			qok_q  <= q_ok;
		end else if (cmd.issue) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qidx_q <= AW'(item.point_index);
			cnt_q  <= cnt_sat;
		end
		if (cmd.cap_q) begin
			qx_q <= px;
			qy_q <= py;
		end
	end

	// distance pipeline: abs diff, squares, sum
	always_comb begin
		diff_x = (COORD_BITS + 1)'(px) - (COORD_BITS + 1)'(qx_q);
		diff_y = (COORD_BITS + 1)'(py) - (COORD_BITS + 1)'(qy_q);
		abs_x  = diff_x[COORD_BITS] ? (COORD_BITS + 1)'(-diff_x) : diff_x;
		abs_y  = diff_y[COORD_BITS] ? (COORD_BITS + 1)'(-diff_y) : diff_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s0 <= cmd.issue;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && !self_s2;
		end
	end

	always_ff @(posedge clk) begin
		i_s0    <= scan_q[AW-1:0];
		i_s1    <= i_s0;
		self_s1 <= i_s0 == qidx_q;
		dx_s1   <= abs_x[COORD_BITS-1:0];
		dy_s1   <= abs_y[COORD_BITS-1:0];
		i_s2    <= i_s1;
		self_s2 <= self_s1;
		sqx_s2  <= SQ_BITS'(dx_s1 * dx_s1);
		sqy_s2  <= SQ_BITS'(dy_s1 * dy_s1);
		i_s3    <= i_s2;
		d2_s3   <= D2_BITS'(sqx_s2) + D2_BITS'(sqy_s2);
	end

	// count and nearest tracking, first index wins on equal distance
	assign hit = v_s3 && (d2_s3 < D2_BITS'(r2_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
			have_q  <= 1'b0;
		end else if (cmd.start) begin
			found_q <= '0;
			have_q  <= 1'b0;
		end else if (hit) begin
			found_q <= found_q + 1'b1;
			have_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && (!have_q || d2_s3 < best_d2_q)) begin
			best_d2_q <= d2_s3;
			best_i_q  <= i_s3;
		end
	end

	frnn_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.root_start),
		.operand (best_d2_q),
		.done    (root_done),
		.root    (root)
	);

	always_comb begin
		stat.q_ok      = q_ok;
		stat.scan_last = CW'(scan_q + 1'b1) == cnt_q;
		stat.pipe_busy = v_s0 || v_s1 || v_s2 || v_s3;
		stat.root_done = root_done;
	end

	always_comb begin
		result.valid_res        = qok_q;
		result.neighbor_count   = found_q;
		result.nearest_distance = have_q ? root : '0;
		result.closest_index    = have_q ? IDX_BITS'(best_i_q) : '0;
	end

endmodule

// ===== src/frnn_ctrl.sv =====
// ----------------------------------------------------------------------------
// frnn_ctrl
// Controller state machine: sequences table writes, query scan, drain,
// square root and result hand-off.
// ----------------------------------------------------------------------------
module frnn_ctrl
	import frnn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_op,
	output logic       item_ready,
	input  logic       res_free,
	input  frnn_stat_t stat,
	output frnn_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_QPT   = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_ROOT  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;

	assign item_ready = state_q == S_IDLE;
	assign accept     = item_valid && item_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.wr    = accept && (item_op == OP_WRITE);
				cmd.start = accept && (item_op == OP_QUERY);
				if (cmd.start) begin
					state_d = stat.q_ok ? S_QPT : S_DONE;
				end
			end
			S_QPT: begin
				cmd.cap_q = 1'b1;
				cmd.issue = 1'b1;
				state_d   = stat.scan_last ? S_DRAIN : S_SCAN;
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!stat.pipe_busy) begin
					cmd.root_start = 1'b1;
					state_d        = S_ROOT;
				end
			end
			S_ROOT: begin
				if (stat.root_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_root_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		stat.root_done |-> state_q == S_ROOT)
		else $error("root done outside root state");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> res_free)
		else $error("result loaded into full output register");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !stat.pipe_busy)
		else $error("distance pipeline busy while idle");

	a_bad_query: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && !stat.q_ok |=> state_q == S_DONE)
		else $error("invalid query did not go straight to result");
`endif

endmodule

// ===== src/fixed_radius_neighbor_search.sv =====
// ----------------------------------------------------------------------------
// fixed_radius_neighbor_search
// Point table with brute-force fixed-radius neighbor query.
//
//   channel  signals                        direction  meaning
//   cfg      cfg_wen, cfg_wdata             in         search radius write
//   item     item_valid, item_ready, item   in         point write or query
//   res      res_valid, res_ready, res      out        query result
//
// A point write is taken in the idle state; an invalid query goes straight to
// the result. A valid query makes one table read per cycle through the single
// read port for each point up to the saturated point count, drains a four-stage
// distance pipeline, then runs 17 iterations of the bit-serial square root. A
// new item is taken only while idle; the output register lets the next item
// enter while a result waits on res_ready. Reset clears control state and sets
// the radius to 200; the table is not cleared.
// ----------------------------------------------------------------------------
module fixed_radius_neighbor_search
	import frnn_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wen,
	input  logic [RADIUS_BITS-1:0] cfg_wdata,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  item_t                  item,
	output logic                   res_valid,
	input  logic                   res_ready,
	output result_t                res
);

	frnn_cmd_t  cmd;
	frnn_stat_t stat;
	result_t    result;
	logic       res_valid_q;
	result_t    res_q;
	logic       res_free;

	assign res_free = !res_valid_q || res_ready;

	frnn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.item_ready (item_ready),
		.res_free   (res_free),
		.stat       (stat),
		.cmd        (cmd)
	);

	frnn_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
